// ===== src/der_pkg.sv =====
// ----------------------------------------------------------------------------
// der_pkg
// shared types and constants for the der tlv element parser
// ----------------------------------------------------------------------------
package der_pkg;

  localparam int unsigned CntW = 4;

  localparam logic [2:0] OP_READ_INT = 3'd0;
  localparam logic [2:0] OP_SEQ_HDR  = 3'd1;
  localparam logic [2:0] OP_SKIP_SEQ = 3'd2;
  localparam logic [2:0] OP_SKIP_INT = 3'd3;
  localparam logic [2:0] OP_OCT_HDR  = 3'd4;
  localparam logic [2:0] OP_BITS_HDR = 3'd5;

  localparam logic [7:0] TAG_INTEGER = 8'h02;
  localparam logic [7:0] TAG_SEQ     = 8'h30;
  localparam logic [7:0] TAG_OCTETS  = 8'h04;
  localparam logic [7:0] TAG_BITS    = 8'h03;
  localparam logic [7:0] LEN_N_MASK  = 8'h7F;

  typedef enum logic [2:0] {
    KIND_HDR      = 3'd0,
    KIND_INT_BYTE = 3'd1,
    KIND_SKIPPED  = 3'd2,
    KIND_TAG_ERR  = 3'd3,
    KIND_LEN_LONG = 3'd4
  } kind_e;

  typedef struct packed {
    logic [7:0]      data;
    logic [2:0]      op;
    logic            op_ok;
    logic            tag_ok;
    logic            long_form;
    logic            n_over;
    logic            n_zero;
    logic [CntW-1:0] n_cnt;
  } class_t;

  function automatic logic [7:0] tag_for_op(input logic [2:0] op);
    logic [7:0] t;
    case (op)
      OP_READ_INT: t = TAG_INTEGER;
      OP_SEQ_HDR:  t = TAG_SEQ;
      OP_SKIP_SEQ: t = TAG_SEQ;
      OP_SKIP_INT: t = TAG_INTEGER;
      OP_OCT_HDR:  t = TAG_OCTETS;
      OP_BITS_HDR: t = TAG_BITS;
      default:     t = 8'h00;
    endcase
    return t;
  endfunction

endpackage

// ===== src/der_tlv_element_parser.sv =====
// ----------------------------------------------------------------------------
// der_tlv_element_parser
// der tlv element parser: byte classifier, queue, sequencer
// ----------------------------------------------------------------------------
// a result is registered in the sequencer's output register after its byte passes the queue
// throughput: one byte per cycle while the result register is not stalled, set by the single-step sequencer
// the queue absorbs two bytes while the result register is stalled
// reset clears phase, counters, queue pointers and output valid
module der_tlv_element_parser #(
  parameter int unsigned LEN_BYTES_MAX = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic  [7:0] data_byte_i,
  input  logic  [2:0] opcode_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic  [2:0] kind_o,
  output logic  [7:0] value_byte_o,
  output logic [31:0] length_o,
  output logic        last_o
);
  import der_pkg::*;

  class_t cls_in;
  class_t cls_out;
  logic   full, empty, pop;

  der_front #(
    .LEN_BYTES_MAX(LEN_BYTES_MAX)
  ) u_front (
    .data_byte_i(data_byte_i),
    .opcode_i   (opcode_i),
    .class_o    (cls_in)
  );

  der_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (in_valid_i),
    .wdata_i(cls_in),
    .full_o (full),
    .pop_i  (pop),
    .empty_o(empty),
    .rdata_o(cls_out)
  );

  der_back #(
    .LEN_BYTES_MAX(LEN_BYTES_MAX)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .item_i      (cls_out),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_o      (kind_o),
    .value_byte_o(value_byte_o),
    .length_o    (length_o),
    .last_o      (last_o)
  );

  assign in_ready_o = !full;

endmodule

// ===== src/der_front.sv =====
// ----------------------------------------------------------------------------
// der_front
// classifies each incoming byte as tag, short or long form length
// ----------------------------------------------------------------------------
module der_front #(
  parameter int unsigned LEN_BYTES_MAX = 4
) (
  input  logic            [7:0] data_byte_i,
  input  logic            [2:0] opcode_i,
  output der_pkg::class_t       class_o
);
  import der_pkg::*;

  localparam logic [6:0] LenMax = 7'(LEN_BYTES_MAX);

  logic [6:0] n_raw;

  assign n_raw = 7'(data_byte_i & LEN_N_MASK);

  always_comb begin
    class_o.data      = data_byte_i;
    class_o.op        = opcode_i;
    class_o.op_ok     = (opcode_i <= OP_BITS_HDR);
    class_o.tag_ok    = (data_byte_i == tag_for_op(opcode_i));
    class_o.long_form = data_byte_i[7];
    class_o.n_over    = (n_raw > LenMax);
    class_o.n_zero    = (n_raw == 7'd0);
    class_o.n_cnt     = n_raw[CntW-1:0];
  end

endmodule

// ===== src/der_fifo.sv =====
// ----------------------------------------------------------------------------
// der_fifo
// two-entry queue between classifier and sequencer
// ----------------------------------------------------------------------------
module der_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  der_pkg::class_t wdata_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output der_pkg::class_t rdata_o
);
  import der_pkg::*;

  class_t     mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ===== src/der_back.sv =====
// ----------------------------------------------------------------------------
// der_back
// tlv sequencer with registered result output
// ----------------------------------------------------------------------------
module der_back #(
  parameter int unsigned LEN_BYTES_MAX = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             empty_i,
  input  der_pkg::class_t  item_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic       [2:0] kind_o,
  output logic       [7:0] value_byte_o,
  output logic      [31:0] length_o,
  output logic             last_o
);
  import der_pkg::*;

  localparam int unsigned CW = $clog2(LEN_BYTES_MAX + 1);

  typedef enum logic [5:0] {
    PH_TAG     = 6'b000001,
    PH_LEN1    = 6'b000010,
    PH_LENN    = 6'b000100,
    PH_CONTENT = 6'b001000,
    PH_UNUSED  = 6'b010000,
    PH_HALT    = 6'b100000
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [2:0]  op_q, op_d;
  logic [31:0] len_q, len_d;
  logic [31:0] left_q, left_d;
  logic [CW-1:0] nleft_q, nleft_d;

  logic        out_valid_q, out_valid_d;
  kind_e       kind_q, kind_d;
  logic [7:0]  value_q, value_d;
  logic [31:0] length_q, length_d;
  logic        last_q, last_d;

  logic        emit;
  logic        do_hd;
  logic [31:0] hd_len;
  logic [31:0] left_dec;

  assign pop_o    = !empty_i && (!out_valid_q || out_ready_i);
  assign left_dec = left_q - 32'd1;

  always_comb begin
    phase_d  = phase_q;
    op_d     = op_q;
    len_d    = len_q;
    left_d   = left_q;
    nleft_d  = nleft_q;
    emit     = 1'b0;
    kind_d   = KIND_HDR;
    value_d  = 8'h00;
    length_d = 32'd0;
    last_d   = 1'b0;
    do_hd    = 1'b0;
    hd_len   = 32'd0;

    case (phase_q)
      PH_TAG: begin
        if (item_i.op_ok) begin
          op_d = item_i.op;
          if (!item_i.tag_ok) begin
            phase_d = PH_HALT;
            emit    = 1'b1;
            kind_d  = KIND_TAG_ERR;
            value_d = item_i.data;
          end else begin
            phase_d = PH_LEN1;
          end
        end
      end
      PH_LEN1: begin
        len_d = 32'd0;
        if (!item_i.long_form) begin
          hd_len = {24'd0, item_i.data};
          do_hd  = 1'b1;
        end else if (item_i.n_over) begin
          phase_d = PH_HALT;
          emit    = 1'b1;
          kind_d  = KIND_LEN_LONG;
        end else if (item_i.n_zero) begin
          do_hd = 1'b1;
        end else begin
          nleft_d = item_i.n_cnt[CW-1:0];
          phase_d = PH_LENN;
        end
      end
      PH_LENN: begin
        hd_len  = {len_q[23:0], item_i.data};
        len_d   = hd_len;
        nleft_d = nleft_q - CW'(1);
        if (nleft_q == CW'(1)) begin
          do_hd = 1'b1;
        end
      end
      PH_CONTENT: begin
        left_d = left_dec;
        if (op_q == OP_READ_INT) begin
          emit     = 1'b1;
          kind_d   = KIND_INT_BYTE;
          value_d  = item_i.data;
          length_d = len_q;
          last_d   = (left_dec == 32'd0);
          if (left_dec == 32'd0) begin
            phase_d = PH_TAG;
          end
        end else if (left_dec == 32'd0) begin
          phase_d  = PH_TAG;
          emit     = 1'b1;
          kind_d   = KIND_SKIPPED;
          length_d = len_q;
          last_d   = 1'b1;
        end
      end
      PH_UNUSED: begin
        phase_d  = PH_TAG;
        emit     = 1'b1;
        kind_d   = KIND_HDR;
        value_d  = item_i.data;
        length_d = len_q;
      end
      default: begin
      end
    endcase

    if (do_hd) begin
      len_d  = hd_len;
      left_d = hd_len;
      case (op_q)
        OP_READ_INT: begin
          phase_d  = (hd_len == 32'd0) ? PH_TAG : PH_CONTENT;
          emit     = 1'b1;
          kind_d   = KIND_HDR;
          length_d = hd_len;
          last_d   = (hd_len == 32'd0);
        end
        OP_SKIP_SEQ, OP_SKIP_INT: begin
          if (hd_len == 32'd0) begin
            phase_d = PH_TAG;
            emit    = 1'b1;
            kind_d  = KIND_SKIPPED;
            last_d  = 1'b1;
          end else begin
            phase_d = PH_CONTENT;
          end
        end
        OP_BITS_HDR: begin
          phase_d = PH_UNUSED;
        end
        default: begin
          phase_d  = PH_TAG;
          emit     = 1'b1;
          kind_d   = KIND_HDR;
          length_d = hd_len;
        end
      endcase
    end

    if (pop_o && emit) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && !out_ready_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_TAG;
      op_q        <= OP_READ_INT;
      len_q       <= 32'd0;
      left_q      <= 32'd0;
      nleft_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        phase_q <= phase_d;
        op_q    <= op_d;
        len_q   <= len_d;
        left_q  <= left_d;
        nleft_q <= nleft_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && emit) begin
      kind_q   <= kind_d;
      value_q  <= value_d;
      length_q <= length_d;
      last_q   <= last_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = kind_q;
  assign value_byte_o = value_q;
  assign length_o     = length_q;
  assign last_o       = last_q;

endmodule

// ===== src/der_checker.sv =====
// ----------------------------------------------------------------------------
// der_checker
// port-level checks for the der tlv element parser
// ----------------------------------------------------------------------------
module der_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic  [2:0] kind_o,
  input logic  [7:0] value_byte_o,
  input logic [31:0] length_o,
  input logic        last_o
);
  import der_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o) &&
      $stable(value_byte_o) && $stable(length_o) && $stable(last_o))
    else $error("result changed while stalled");

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> kind_o <= KIND_LEN_LONG)
    else $error("result kind out of range");

  a_skip_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_SKIPPED |-> last_o && value_byte_o == 8'h00)
    else $error("skip result without end mark");

  a_err_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_TAG_ERR || kind_o == KIND_LEN_LONG) |->
      length_o == 32'd0 && !last_o)
    else $error("error result with length or end mark");

endmodule

bind der_tlv_element_parser der_checker u_der_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .kind_o      (kind_o),
  .value_byte_o(value_byte_o),
  .length_o    (length_o),
  .last_o      (last_o)
);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking testbench for the der tlv element parser: directed and random
// tlv byte streams, random idling on both sides, a long output stall, and a
// halting error at the end, every result checked against an in-order predictor
// ----------------------------------------------------------------------------
module tb_top;
  import der_pkg::*;

  localparam int unsigned LenBytesMax = 4;
  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned RandomBytes = 660;
  localparam int unsigned SteadyBytes = 120;
  localparam int unsigned StallBytes  = 60;
  localparam int unsigned ShownErrors = 10;

  localparam logic [2:0] OP_FIRST_UNUSED = 3'd6;
  localparam logic [2:0] OP_LAST_UNUSED  = 3'd7;
  localparam logic [7:0] LEN_LONG_FLAG   = 8'h80;

  typedef enum logic [2:0] {
    SCAN_TAG,
    SCAN_LEN1,
    SCAN_LENN,
    SCAN_CONTENT,
    SCAN_UNUSED,
    SCAN_HALT
  } scan_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  value_byte;
    logic [31:0] length;
    logic        last;
  } tlv_report_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic  [7:0] data_byte_i;
  logic  [2:0] opcode_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic  [2:0] kind_o;
  logic  [7:0] value_byte_o;
  logic [31:0] length_o;
  logic        last_o;

  // predictor state
  scan_e       scan_phase;
  logic  [2:0] elem_op;
  logic [31:0] len_value;
  logic [31:0] bytes_to_go;
  logic  [3:0] len_digits_left;

  tlv_report_t tlv_reports_q[$];
  int unsigned mismatch_count;
  int unsigned bytes_sent;
  int unsigned idle_cycles;
  int unsigned rx_hold_len;
  bit          tx_steady;
  bit          rx_steady;

  der_tlv_element_parser #(
    .LEN_BYTES_MAX(LenBytesMax)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .opcode_i    (opcode_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_o      (kind_o),
    .value_byte_o(value_byte_o),
    .length_o    (length_o),
    .last_o      (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [7:0] element_tag(input logic [2:0] op);
    logic [7:0] t;
    case (op)
      OP_READ_INT, OP_SKIP_INT: t = TAG_INTEGER;
      OP_SEQ_HDR, OP_SKIP_SEQ:  t = TAG_SEQ;
      OP_OCT_HDR:               t = TAG_OCTETS;
      default:                  t = TAG_BITS;
    endcase
    return t;
  endfunction

  function automatic logic [2:0] any_opcode();
    return 3'($urandom());
  endfunction

  task automatic push_report(input kind_e k, input logic [7:0] vb, input logic [31:0] len,
                             input logic lst);
    tlv_reports_q.push_back('{k, vb, len, lst});
  endtask

  // length field complete: act on the sampled opcode
  task automatic close_length();
    bytes_to_go = len_value;
    case (elem_op)
      OP_READ_INT: begin
        scan_phase = (len_value == 0) ? SCAN_TAG : SCAN_CONTENT;
        push_report(KIND_HDR, 8'h00, len_value, len_value == 0);
      end
      OP_SKIP_SEQ, OP_SKIP_INT: begin
        if (len_value == 0) begin
          scan_phase = SCAN_TAG;
          push_report(KIND_SKIPPED, 8'h00, 32'd0, 1'b1);
        end else begin
          scan_phase = SCAN_CONTENT;
        end
      end
      OP_BITS_HDR: scan_phase = SCAN_UNUSED;
      default: begin
        scan_phase = SCAN_TAG;
        push_report(KIND_HDR, 8'h00, len_value, 1'b0);
      end
    endcase
  endtask

  task automatic parse_tlv_byte(input logic [7:0] b, input logic [2:0] op);
    case (scan_phase)
      SCAN_TAG: begin
        if (op <= OP_BITS_HDR) begin
          elem_op = op;
          if (b != element_tag(op)) begin
            scan_phase = SCAN_HALT;
            push_report(KIND_TAG_ERR, b, 32'd0, 1'b0);
          end else begin
            scan_phase = SCAN_LEN1;
          end
        end
      end
      SCAN_LEN1: begin
        len_value = '0;
        if (!b[7]) begin
          len_value = {24'd0, b};
          close_length();
        end else if ((b & LEN_N_MASK) > LenBytesMax) begin
          scan_phase = SCAN_HALT;
          push_report(KIND_LEN_LONG, 8'h00, 32'd0, 1'b0);
        end else if ((b & LEN_N_MASK) == 0) begin
          close_length();
        end else begin
          len_digits_left = 4'(b & LEN_N_MASK);
          scan_phase = SCAN_LENN;
        end
      end
      SCAN_LENN: begin
        len_value = {len_value[23:0], b};
        len_digits_left = len_digits_left - 4'd1;
        if (len_digits_left == 0) close_length();
      end
      SCAN_CONTENT: begin
        bytes_to_go = bytes_to_go - 32'd1;
        if (elem_op == OP_READ_INT) begin
          if (bytes_to_go == 0) scan_phase = SCAN_TAG;
          push_report(KIND_INT_BYTE, b, len_value, bytes_to_go == 0);
        end else if (bytes_to_go == 0) begin
          scan_phase = SCAN_TAG;
          push_report(KIND_SKIPPED, 8'h00, len_value, 1'b1);
        end
      end
      SCAN_UNUSED: begin
        scan_phase = SCAN_TAG;
        push_report(KIND_HDR, b, len_value, 1'b0);
      end
      default: ;
    endcase
  endtask

  // one request on the input channel, predicted once accepted
  task automatic send_byte(input logic [7:0] b, input logic [2:0] op);
    if (!tx_steady && $urandom_range(99) < 16) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    opcode_i    <= op;
    do @(posedge clk_i); while (!in_ready_o);
    parse_tlv_byte(b, op);
    bytes_sent++;
  endtask

  // long form with no digits is the indefinite form
  task automatic send_length(input bit short_form, input logic [31:0] len, input int digits);
    if (short_form) begin
      send_byte(len[7:0], any_opcode());
    end else begin
      send_byte(LEN_LONG_FLAG | 8'(digits), any_opcode());
      for (int i = digits - 1; i >= 0; i--) send_byte(len[8*i +: 8], any_opcode());
    end
  endtask

  task automatic send_element(input logic [2:0] op, input bit short_form,
                              input logic [31:0] len, input int digits);
    send_byte(element_tag(op), op);
    send_length(short_form, len, digits);
    if (op inside {OP_READ_INT, OP_SKIP_SEQ, OP_SKIP_INT}) begin
      repeat (len) send_byte(8'($urandom()), any_opcode());
    end else if (op == OP_BITS_HDR) begin
      send_byte(8'($urandom()), any_opcode());
    end
  endtask

  task automatic send_random_element();
    logic [2:0]  op;
    logic [31:0] len;
    int          digits;
    bit          short_form;
    bit          with_content;
    int unsigned pick;
    op = 3'($urandom_range(OP_READ_INT, OP_BITS_HDR));
    with_content = op inside {OP_READ_INT, OP_SKIP_SEQ, OP_SKIP_INT};
    if (with_content) begin
      len = ($urandom_range(19) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 8);
    end else begin
      len = $urandom();
    end
    pick = $urandom_range(9);
    digits = 0;
    short_form = 1'b0;
    if (pick == 0) begin
      len = '0;
    end else if (pick < 5) begin
      short_form = 1'b1;
      len = len & 32'h7F;
    end else begin
      digits = $urandom_range(1, LenBytesMax);
      if (with_content) begin
        if (len > 255 && digits < 2) digits = 2;
      end else begin
        len = len >> (8 * (LenBytesMax - digits));
      end
    end
    send_element(op, short_form, len, digits);
  endtask

  task automatic test_directed_elements();
    send_element(OP_READ_INT, 1'b1, 32'd0, 0);
    send_byte(TAG_INTEGER, OP_READ_INT);
    send_byte(8'd2, any_opcode());
    send_byte(8'hFF, any_opcode());
    send_byte(8'h00, any_opcode());
    send_element(OP_SEQ_HDR, 1'b0, 32'd0, 0);
    send_element(OP_SKIP_SEQ, 1'b1, 32'd0, 0);
    send_element(OP_SKIP_INT, 1'b0, 32'd1, 1);
    send_element(OP_OCT_HDR, 1'b0, 32'hFFFF_FFFF, LenBytesMax);
    send_byte(TAG_BITS, OP_BITS_HDR);
    send_byte(LEN_N_MASK, any_opcode());
    send_byte(8'h07, any_opcode());
    send_byte(8'hFF, OP_LAST_UNUSED);
  endtask

  // output held off while integer bytes keep coming
  task automatic test_output_stall();
    int unsigned stop_at;
    stop_at = bytes_sent + StallBytes;
    rx_hold_len = HoldCycles;
    while (bytes_sent < stop_at) send_element(OP_READ_INT, 1'b1, $urandom_range(1, 8), 0);
  endtask

  task automatic test_random_stream();
    int unsigned stop_at;
    int unsigned steady_until;
    stop_at = bytes_sent + RandomBytes;
    steady_until = bytes_sent + SteadyBytes;
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    while (bytes_sent < stop_at) begin
      if (bytes_sent >= steady_until) begin
        tx_steady = 1'b0;
        rx_steady = 1'b0;
      end
      if ($urandom_range(11) == 0) begin
        send_byte(8'($urandom()), 3'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED)));
      end
      send_random_element();
    end
  endtask

  // wrong tag or over-long length, then bytes the halted block must drop
  task automatic test_halting_error();
    logic [2:0] op;
    op = 3'($urandom_range(OP_READ_INT, OP_BITS_HDR));
    if ($urandom_range(1) == 0) begin
      send_byte(element_tag(op) ^ 8'($urandom_range(1, 255)), op);
    end else begin
      send_byte(element_tag(op), op);
      send_byte(LEN_LONG_FLAG | 8'($urandom_range(LenBytesMax + 1, LEN_N_MASK)), any_opcode());
    end
    send_byte(element_tag(op), op);
    repeat (4) send_byte(8'($urandom()), any_opcode());
  endtask

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= ShownErrors) $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  initial begin
    forever begin
      @(posedge clk_i);
      if (rx_hold_len != 0) begin
        out_ready_i <= 1'b0;
        repeat (rx_hold_len) @(posedge clk_i);
        rx_hold_len = 0;
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= rx_steady || ($urandom_range(99) >= 16);
      end
    end
  end

  always @(posedge clk_i) begin
    tlv_report_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (tlv_reports_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected result kind=%0d value=%02h length=%08h last=%0d",
                                kind_o, value_byte_o, length_o, last_o));
      end else begin
        want = tlv_reports_q.pop_front();
        if (kind_o !== want.kind || value_byte_o !== want.value_byte ||
            length_o !== want.length || last_o !== want.last) begin
          flag_mismatch($sformatf({"expected kind=%0d value=%02h length=%08h last=%0d, ",
                                   "got kind=%0d value=%02h length=%08h last=%0d"},
                                  want.kind, want.value_byte, want.length, want.last,
                                  kind_o, value_byte_o, length_o, last_o));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("FAILURE");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    data_byte_i     = 8'h00;
    opcode_i        = OP_READ_INT;
    out_ready_i     = 1'b0;
    tx_steady       = 1'b0;
    rx_steady       = 1'b0;
    rx_hold_len     = 0;
    mismatch_count  = 0;
    bytes_sent      = 0;
    idle_cycles     = 0;
    scan_phase      = SCAN_TAG;
    elem_op         = OP_READ_INT;
    len_value       = '0;
    bytes_to_go     = '0;
    len_digits_left = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_elements();
    test_output_stall();
    test_random_stream();
    test_halting_error();
    in_valid_i <= 1'b0;
    while (tlv_reports_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
